### rtl/core/float_rgb_to_shared_exponent_macros.svh
// Assertion macros for the shared-exponent encoder.
// Used by rtl/core modules that check their own pipeline logic.
`ifndef FLOAT_RGB_TO_SHARED_EXPONENT_MACROS_SVH
`define FLOAT_RGB_TO_SHARED_EXPONENT_MACROS_SVH
`ifndef SYNTHESIS
`define RGBE_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define RGBE_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define RGBE_ASSERT_IMPL(label, clk, rst, a, c)
`define RGBE_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### rtl/core/rgbe_pkg.sv
// Shared types and constants for the shared-exponent encoder.
// No dependencies.
package rgbe_pkg;
  localparam logic [7:0]  ExpOffset = 8'd134;
  localparam logic [7:0]  MinExp    = 8'd7;
  localparam logic [7:0]  ExpSpecial = 8'hFF;

  // One channel after unpacking: effective exponent and significand.
  typedef struct packed {
    logic [7:0]  eff;
    logic [23:0] sig;
  } chan_t;

  typedef struct packed {
    chan_t [2:0] ch;
    logic        bad;
  } stage1_t;

  typedef struct packed {
    chan_t [2:0] ch;
    logic [7:0]  max_exp;
    logic        bad;
    logic        zero;
  } stage2_t;

  typedef struct packed {
    logic [2:0][7:0] mant;
    logic [7:0]      expo;
    logic            invalid;
  } result_t;
endpackage

### rtl/core/rgbe_stage.sv
// One pipeline register stage with elastic valid/ready handshake.
// Depends on nothing; payload width given by parameter.
module rgbe_stage #(
  parameter int unsigned Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [Width-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Width-1:0] out_data
);
  // Accept when empty or when the held word leaves this cycle.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end
endmodule

### rtl/core/float_rgb_to_shared_exponent.sv
// Shared-exponent RGB encoder: three float32 in, 8-bit mantissas and exponent out.
// Stages: unpack, max select, shift; throughput one word per cycle while the output is ready.
// Each stage is an elastic register; a stall holds words in place.
// Reset (rst, synchronous, active high) empties the pipeline; no other state.
// Depends on rgbe_pkg, rgbe_stage and float_rgb_to_shared_exponent_macros.svh.
`include "float_rgb_to_shared_exponent_macros.svh"
module float_rgb_to_shared_exponent
  import rgbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // red_bits, green_bits, blue_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // red, green, blue mantissa, exponent, invalid, pad
);
  stage1_t s1_d, s1_q;
  stage2_t s2_d, s2_q;
  result_t s3_d, s3_q;
  logic v1, r1, v2, r2;

  // Unpack: effective exponent, hidden bit, invalid inputs.
  always_comb begin
    logic [31:0] b;
    logic [7:0]  e;
    s1_d.bad = 1'b0;
    for (int i = 0; i < 3; i++) begin
      b = s_axis_tdata[32*i +: 32];
      e = b[30:23];
      s1_d.ch[i].eff = (e == 8'd0) ? 8'd1 : e;
      s1_d.ch[i].sig = {(e != 8'd0), b[22:0]};
      if (b[31] || e == ExpSpecial) s1_d.bad = 1'b1;
    end
  end

  rgbe_stage #(.Width($bits(stage1_t))) u_st1 (
    .clk, .rst, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s1_d), .out_valid(v1), .out_ready(r1), .out_data(s1_q));

  // Largest exponent; the max channel's exponent is all the shift needs.
  always_comb begin
    logic [7:0] m;
    m = s1_q.ch[0].eff;
    if (s1_q.ch[1].eff > m) m = s1_q.ch[1].eff;
    if (s1_q.ch[2].eff > m) m = s1_q.ch[2].eff;
    s2_d.ch      = s1_q.ch;
    s2_d.max_exp = m;
    s2_d.bad     = s1_q.bad;
    s2_d.zero    = (s1_q.ch[0].sig == 24'd0) && (s1_q.ch[1].sig == 24'd0)
                   && (s1_q.ch[2].sig == 24'd0);
  end

  rgbe_stage #(.Width($bits(stage2_t))) u_st2 (
    .clk, .rst, .in_valid(v1), .in_ready(r1), .in_data(s2_d),
    .out_valid(v2), .out_ready(r2), .out_data(s2_q));

  // Shift each significand; flag a tiny or subnormal maximum.
  always_comb begin
    logic [8:0] sh;
    logic       tiny;
    // A subnormal max has no hidden bit, so its field is zero: also tiny.
    tiny = (s2_q.max_exp < MinExp) ||
           ((s2_q.max_exp == 8'd1) && !(s2_q.ch[0].sig[23] || s2_q.ch[1].sig[23]
            || s2_q.ch[2].sig[23]));
    s3_d.invalid = s2_q.bad || (!s2_q.zero && tiny);
    s3_d.expo    = (s3_d.invalid || s2_q.zero) ? 8'd0 : s2_q.max_exp - ExpOffset;
    for (int i = 0; i < 3; i++) begin
      sh = {1'b0, s2_q.max_exp - s2_q.ch[i].eff} + 9'd16;
      if (s3_d.invalid || s2_q.zero || sh >= 9'd24) s3_d.mant[i] = 8'd0;
      else s3_d.mant[i] = 8'(s2_q.ch[i].sig >> sh[4:0]);
    end
  end

  rgbe_stage #(.Width($bits(result_t))) u_st3 (
    .clk, .rst, .in_valid(v2), .in_ready(r2), .in_data(s3_d),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(s3_q));

  assign m_axis_tdata = {7'd0, s3_q.invalid, s3_q.expo,
                         s3_q.mant[2], s3_q.mant[1], s3_q.mant[0]};

  `RGBE_ASSERT_IMPL(a_inv_zero, clk, rst, m_axis_tvalid && s3_q.invalid, m_axis_tdata[31:0] == 32'd0)
  `RGBE_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `RGBE_ASSERT_IMPL(a_ready, clk, rst, !v1, s_axis_tready)
endmodule

### bench/tb_float_rgb_to_shared_exponent.sv
// Testbench for the shared-exponent RGB encoder: random and directed float triples.
// Drives the input stream in bursts, stalls the output, and checks every word
// against a behavioral predictor. Depends on rgbe_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_float_rgb_to_shared_exponent;
  import rgbe_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] expo;
    logic       invalid;
  } rgbe_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  float_rgb_to_shared_exponent dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  logic [95:0] pending_words[$];
  rgbe_t       encoded_words[$];
  int          errors = 0;
  int          cycles = 0;
  bit          feed_done = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  bit          hold_armed = 1;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] scale_chan(logic [31:0] f, logic [7:0] max_exp);
    logic [7:0]  e;
    logic [23:0] sig;
    logic [8:0]  sh;
    e   = f[30:23];
    sig = {(e != 0), f[22:0]};
    if (e == 0) e = 8'd1;
    if (e > max_exp) return 8'd0;
    sh = {1'b0, max_exp - e} + 9'd16;
    if (sh >= 9'd32) return 8'd0;
    return 8'(sig >> sh);
  endfunction

  function automatic rgbe_t encode_rgb(logic [95:0] w);
    rgbe_t r;
    logic [31:0] c[3];
    logic [31:0] mx;
    logic [7:0]  me;
    r = '0;
    c[0] = w[31:0]; c[1] = w[63:32]; c[2] = w[95:64];
    for (int i = 0; i < 3; i++)
      if (c[i][31] || c[i][30:23] == 8'hFF) r.invalid = 1'b1;
    if (r.invalid) return r;
    mx = c[0];
    if (c[1] > mx) mx = c[1];
    if (c[2] > mx) mx = c[2];
    if (mx == 0) return r;
    me = mx[30:23];
    if (me < 8'd7) begin
      r.invalid = 1'b1;
      return r;
    end
    r.red   = scale_chan(c[0], me);
    r.green = scale_chan(c[1], me);
    r.blue  = scale_chan(c[2], me);
    r.expo  = me - 8'd134;
    return r;
  endfunction

  task automatic report(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] rand_float(int kind);
    logic [31:0] f;
    f = $urandom;
    case (kind)
      0: f[31] = 1'b0;
      1: begin f[31] = 1'b0; f[30:23] = 8'(120 + $urandom_range(0, 16)); end
      2: begin f[31] = 1'b0; f[30:23] = 8'($urandom_range(0, 10)); end
      3: f = 32'd0;
      default: ;
    endcase
    return f;
  endfunction

  initial begin
    int k;
    logic [31:0] a, b, c;
    // directed: zeros, signs, inf/nan, small max, subnormals, ties, extremes
    pending_words.push_back('0);
    pending_words.push_back({32'h0, 32'h0, 32'h8000_0000});
    pending_words.push_back({32'h3F80_0000, 32'h0, 32'hBF80_0000});
    pending_words.push_back({32'h7F80_0000, 32'h0, 32'h0});
    pending_words.push_back({32'h0, 32'h7FC0_0001, 32'h3F80_0000});
    pending_words.push_back({32'h0, 32'h0, 32'h0000_0001});
    pending_words.push_back({32'h0, 32'h0, 32'h0300_0000});
    pending_words.push_back({32'h0, 32'h0, 32'h0380_0000});
    pending_words.push_back({32'h0000_0005, 32'h0380_0000, 32'h007F_FFFF});
    pending_words.push_back({32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF});
    pending_words.push_back({32'h3F80_0000, 32'h3F80_0000, 32'h3F00_0000});
    pending_words.push_back({32'h4000_0000, 32'h3F80_0000, 32'h3E80_0000});
    pending_words.push_back({32'h4B7F_FFFF, 32'h437F_0000, 32'h0});
    pending_words.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pending_words.push_back({32'h7FFF_FFFF, 32'h0, 32'h0});
    for (int i = 0; i < 900; i++) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        a = rand_float(1); b = rand_float(1); c = rand_float($urandom_range(0, 3));
      end else if (k < 8) begin
        a = rand_float(2); b = rand_float(2); c = rand_float($urandom_range(0, 3));
      end else begin
        a = rand_float(4); b = rand_float(0); c = rand_float($urandom_range(0, 4));
      end
      case ($urandom_range(0, 2))
        0: pending_words.push_back({a, b, c});
        1: pending_words.push_back({b, c, a});
        default: pending_words.push_back({c, a, b});
      endcase
    end
    feed_done = 1;
  end

  // driver: bursts and gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) encoded_words.push_back(encode_rgb(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_words.pop_front();
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check and stall the output side
  always @(posedge clk) begin
    rgbe_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{red: m_axis_tdata[7:0], green: m_axis_tdata[15:8],
                blue: m_axis_tdata[23:16], expo: m_axis_tdata[31:24],
                invalid: m_axis_tdata[32]};
        if (encoded_words.size() == 0) begin
          report("unexpected word", m_axis_tdata, '0);
        end else begin
          want = encoded_words.pop_front();
          if (got.red != want.red)
            report("red", 40'(got.red), 40'(want.red));
          if (got.green != want.green)
            report("green", 40'(got.green), 40'(want.green));
          if (got.blue != want.blue)
            report("blue", 40'(got.blue), 40'(want.blue));
          if (got.expo != want.expo)
            report("exponent", 40'(got.expo), 40'(want.expo));
          if (got.invalid != want.invalid)
            report("invalid", 40'(got.invalid), 40'(want.invalid));
        end
      end
      // one long hold-off early in the run to back up the pipeline
      if (hold_armed && cycles > 200) begin
        hold_armed = 0;
        hold_left  = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if ((cycles / 64) % 3 == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (feed_done && pending_words.size() == 0 && !s_axis_tvalid
          && encoded_words.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0 && encoded_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 40000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/rgbe_pkg.sv
rtl/core/rgbe_stage.sv
rtl/core/float_rgb_to_shared_exponent.sv
bench/tb_float_rgb_to_shared_exponent.sv
